@@ sv/urf_pkg.sv @@
// Shared types, constants and register codes for the ultrasonic range filter.
`timescale 1ns / 1ps
package urf_pkg;

    localparam int SENSOR_COUNT_DEF = 4;
    localparam int QUEUE_DEPTH      = 2;

    localparam int WIDTH_W    = 16;
    localparam int DIST_W     = 13;
    localparam int SLOT_BITS  = 4;
    localparam int ALPHA_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 40;

    // 0.1715 mm per microsecond in Q16
    localparam int TOF_MULT  = 11239;
    localparam int TOF_SHIFT = 16;
    localparam int PROD_W    = 30;

    localparam int TIMEOUT_MIN_US = 1500;
    localparam int TIMEOUT_MAX_US = 30000;
    localparam int ALPHA_ONE      = 256;

    localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ALPHA     = 3'd4;

    localparam logic [DIST_W-1:0]  MIN_RANGE_RST = 13'd30;
    localparam logic [DIST_W-1:0]  MAX_RANGE_RST = 13'd4500;
    localparam logic [DIST_W-1:0]  THRESHOLD_RST = 13'd600;
    localparam logic [ALPHA_W-1:0] ALPHA_RST     = 9'd90;

    typedef struct packed {
        logic               enable;
        logic [DIST_W-1:0]  min_range_mm;
        logic [DIST_W-1:0]  max_range_mm;
        logic [DIST_W-1:0]  obstacle_threshold_mm;
        logic [ALPHA_W-1:0] filter_alpha;
    } cfg_t;

    // one classified echo between front and back
    typedef struct packed {
        logic              good;
        logic [DIST_W-1:0] dist_mm;
    } qent_t;

endpackage

@@ sv/urf_front.sv @@
// Front end: accepts echo widths, checks timeout, converts to mm and range-checks.
`timescale 1ns / 1ps
module urf_front
    import urf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] echo_width_us
    input  logic               q_full,
    output logic               q_push,
    output qent_t              q_data
);

    logic               v1_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  prod_next;
    logic               inr_reg;
    logic               inr_next;
    logic [WIDTH_W-1:0] width;
    logic [18:0]        width_x5;
    logic [18:0]        max_x29;
    logic [TOF_SHIFT-3:0] dist_full;
    logic               accept;

    assign width    = s_tdata[WIDTH_W-1:0];
    assign s_tready = !v1_reg || !q_full;
    assign accept   = s_tvalid && s_tready;

    // width <= clamp(floor(max*29/5)) rewritten as 5*width <= 29*max plus the clamp bounds
    assign width_x5 = 19'({width, 2'b00}) + 19'(width);
    assign max_x29  = 19'({cfg.max_range_mm, 5'b00000}) - 19'({cfg.max_range_mm, 1'b0})
                    - 19'(cfg.max_range_mm);

    always_comb begin
        prod_next = PROD_W'(width) * PROD_W'(TOF_MULT);
        inr_next  = (width != '0) &&
                    ((width <= WIDTH_W'(TIMEOUT_MIN_US)) ||
                     ((width_x5 <= max_x29) && (width <= WIDTH_W'(TIMEOUT_MAX_US))));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (accept) begin
            v1_reg <= 1'b1;
        end else if (!q_full) begin
            v1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            prod_reg <= prod_next;
            inr_reg  <= inr_next;
        end
    end

    assign dist_full = prod_reg[PROD_W-1:TOF_SHIFT];
    assign q_push    = v1_reg && !q_full;

    always_comb begin
        q_data.dist_mm = dist_full[DIST_W-1:0];
        q_data.good    = inr_reg &&
                         (dist_full >= 14'(cfg.min_range_mm)) &&
                         (dist_full <= 14'(cfg.max_range_mm));
    end

endmodule

@@ sv/urf_queue.sv @@
// Short FIFO between the classifying front end and the filter back end.
`timescale 1ns / 1ps
module urf_queue
    import urf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  qent_t push_data,
    output logic  full,
    input  logic  pop,
    output logic  not_empty,
    output qent_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    qent_t            mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   count_reg;

    assign full      = (count_reg == (PTR_W+1)'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/urf_back.sv @@
// Back end: per-sensor filter update, nearest-distance scan and result register.
`timescale 1ns / 1ps
module urf_back
    import urf_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                q_valid,
    input  qent_t               q_data,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam int SLOT_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SENSOR_COUNT - 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WR   = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    logic [DIST_W-1:0]   store_reg [SENSOR_COUNT];
    logic                valid_reg [SENSOR_COUNT];
    logic [SLOT_W-1:0]   cur_slot_reg;
    logic [SLOT_W-1:0]   item_slot_reg;
    logic [SLOT_W-1:0]   scan_idx_reg;
    qent_t               item_reg;
    logic signed [23:0]  mul_reg;
    logic [DIST_W-1:0]   near_reg;
    logic                any_reg;
    logic                m_tvalid_reg;
    logic [M_DATA_W-1:0] m_tdata_reg;

    logic [SLOT_W-1:0]   rd_idx;
    logic [DIST_W-1:0]   rd_dist;
    logic                rd_valid;
    logic [ALPHA_W-1:0]  alpha_sat;
    logic signed [13:0]  diff;
    logic signed [23:0]  blend_sum;
    logic [DIST_W-1:0]   blend;
    logic [DIST_W-1:0]   out_filtered;
    logic                out_obstacle;
    logic                out_load;

    // single read port: scan index while scanning, item slot otherwise
    assign rd_idx   = (state_reg == S_SCAN) ? scan_idx_reg : item_slot_reg;
    assign rd_dist  = store_reg[rd_idx];
    assign rd_valid = valid_reg[rd_idx];

    assign alpha_sat = (cfg.filter_alpha > ALPHA_W'(ALPHA_ONE)) ? ALPHA_W'(ALPHA_ONE)
                                                               : cfg.filter_alpha;
    // old*(256-a) + new*a == old*256 + (new-old)*a
    assign diff      = $signed({1'b0, item_reg.dist_mm}) - $signed({1'b0, rd_dist});
    assign blend_sum = $signed({3'b000, rd_dist, 8'h00}) + mul_reg;
    assign blend     = blend_sum[20:8];

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_OUT) && (!m_tvalid_reg || m_tready);

    assign out_filtered = rd_valid ? rd_dist : '0;
    assign out_obstacle = cfg.enable && any_reg && (near_reg <= cfg.obstacle_threshold_mm);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    state_next = cfg.enable ? S_MUL : S_SCAN;
                end
            end
            S_MUL:  state_next = S_WR;
            S_WR:   state_next = S_SCAN;
            S_SCAN: begin
                if (scan_idx_reg == LAST_SLOT) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            cur_slot_reg <= '0;
            scan_idx_reg <= '0;
            m_tvalid_reg <= 1'b0;
            for (int i = 0; i < SENSOR_COUNT; i++) begin
                store_reg[i] <= '0;
                valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg <= state_next;
            if (state_reg == S_WR) begin
                if (!item_reg.good) begin
                    store_reg[item_slot_reg] <= '0;
                end else if (!rd_valid) begin
                    store_reg[item_slot_reg] <= item_reg.dist_mm;
                end else begin
                    store_reg[item_slot_reg] <= blend;
                end
                valid_reg[item_slot_reg] <= item_reg.good;
                cur_slot_reg <= (cur_slot_reg == LAST_SLOT) ? '0 : cur_slot_reg + 1'b1;
            end
            if (state_reg == S_SCAN) begin
                scan_idx_reg <= (scan_idx_reg == LAST_SLOT) ? '0 : scan_idx_reg + 1'b1;
            end else begin
                scan_idx_reg <= '0;
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop) begin
            item_reg      <= q_data;
            item_slot_reg <= cur_slot_reg;
            near_reg      <= '0;
            any_reg       <= 1'b0;
        end
        if (state_reg == S_MUL) begin
            mul_reg <= diff * $signed({1'b0, alpha_sat});
        end
        if (state_reg == S_SCAN && rd_valid) begin
            if (!any_reg || rd_dist < near_reg) begin
                near_reg <= rd_dist;
            end
            any_reg <= 1'b1;
        end
        if (out_load) begin
            m_tdata_reg <= {7'b0000000, out_obstacle, any_reg, near_reg, rd_valid,
                            out_filtered, SLOT_BITS'(item_slot_reg)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

@@ sv/ultrasonic_range_filter.sv @@
// Ultrasonic range filter top level: config registers, front end, queue and back end.
// Each echo width (us) goes to the sensor slot chosen round-robin; the front end registers
// the request, turns it into a classified distance and queues it, the back end updates that
// slot's filtered distance (while enabled) and then walks all sensors one per cycle to find
// the nearest valid one. The front end can take the next request while the back end is busy.
// Configuration writes are always ready and take effect on the next cycle.
`timescale 1ns / 1ps
module ultrasonic_range_filter
    import urf_pkg::*;
#(
    parameter int SENSOR_COUNT = SENSOR_COUNT_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [15:0] echo_width_us
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [3:0] sensor_slot, [16:4] filtered_mm, [17] slot_valid, [30:18] nearest_mm,
    // [31] any_valid, [32] obstacle, [39:33] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg;
    logic  q_full;
    logic  q_push;
    qent_t q_in;
    logic  q_pop;
    logic  q_valid;
    qent_t q_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable                <= 1'b1;
            cfg_reg.min_range_mm          <= MIN_RANGE_RST;
            cfg_reg.max_range_mm          <= MAX_RANGE_RST;
            cfg_reg.obstacle_threshold_mm <= THRESHOLD_RST;
            cfg_reg.filter_alpha          <= ALPHA_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_ENABLE:    cfg_reg.enable                <= cfg_data[0];
                REG_MIN_RANGE: cfg_reg.min_range_mm          <= cfg_data;
                REG_MAX_RANGE: cfg_reg.max_range_mm          <= cfg_data;
                REG_THRESHOLD: cfg_reg.obstacle_threshold_mm <= cfg_data;
                REG_ALPHA:     cfg_reg.filter_alpha          <= cfg_data[ALPHA_W-1:0];
                default: ;
            endcase
        end
    end

    urf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    urf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_out)
    );

    urf_back #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
